// ----- rtl/pts_pkg.sv -----
package pts_pkg;

    // Action codes carried in the input word.
    localparam logic [3:0] ACT_TICK        = 4'd0;
    localparam logic [3:0] ACT_YIELD       = 4'd1;
    localparam logic [3:0] ACT_SLEEP_TICKS = 4'd2;
    localparam logic [3:0] ACT_SLEEP_EVENT = 4'd3;
    localparam logic [3:0] ACT_WAKE_TASK   = 4'd4;
    localparam logic [3:0] ACT_WAKE_EVENT  = 4'd5;
    localparam logic [3:0] ACT_BLOCK       = 4'd6;
    localparam logic [3:0] ACT_UNBLOCK     = 4'd7;
    localparam logic [3:0] ACT_SET_PRIO    = 4'd8;

    // Task status codes.
    localparam logic [1:0] ST_READY    = 2'd0;
    localparam logic [1:0] ST_RUNNING  = 2'd1;
    localparam logic [1:0] ST_SLEEPING = 2'd2;
    localparam logic [1:0] ST_BLOCKED  = 2'd3;

    localparam logic [7:0] PRIO_NONE = 8'd255;
    localparam logic [3:0] TASK_COUNT_RESET = 4'd8;

    typedef struct packed {
        logic [3:0]         action;
        logic [2:0]         task_index;
        logic [31:0]        tick_count;
        logic signed [31:0] event_id;
        logic [7:0]         new_priority;
    } in_word_t;

    typedef struct packed {
        logic       switched;
        logic [2:0] running_task;
        logic [2:0] previous_task;
        logic       woke_any;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the input word, apply the pre-scan update
        logic scan;     // examine one ring slot
        logic commit;   // apply the pick and build the result word
    } pts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;  // the slot being examined is the last of the ring
    } pts_stat_t;

endpackage

// ----- rtl/pts_ctrl.sv -----
module pts_ctrl
    import pts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  pts_stat_t stat,
    output pts_cmd_t  cmd
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Idle accepts a word; the scan walks the ring one slot per cycle.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Commit once the output register is free.
                if (!out_valid_next)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/pts_datapath.sv -----
module pts_datapath
    import pts_pkg::*;
#(
    parameter int NUM_TASKS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_word_t  in_word,
    input  logic      cfg_write,
    input  logic [3:0] cfg_data,
    input  pts_cmd_t  cmd,
    output pts_stat_t stat,
    output out_word_t out_word
);

    localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CW = $clog2(NUM_TASKS + 1);

    logic [1:0]        status_reg [NUM_TASKS];
    logic [7:0]        prio_reg   [NUM_TASKS];
    logic [31:0]       sleep_reg  [NUM_TASKS];
    logic [31:0]       event_reg  [NUM_TASKS];
    logic [IW-1:0]     cur_reg;
    logic [3:0]        count_reg;

    logic [IW-1:0]     prev_reg;
    logic              woke_reg;
    logic              sched_reg;     // this action runs the scheduler
    logic              tick_reg;      // tick form: old current set ready on a pick
    logic [IW-1:0]     idx_reg;       // slot under examination
    logic [CW-1:0]     left_reg;      // slots still to examine
    logic [7:0]        best_reg;
    logic [IW-1:0]     pick_reg;
    logic              found_reg;
    out_word_t         out_reg;

    // Ring size, clamped to 1..NUM_TASKS.
    logic [CW-1:0] ring_n;
    always_comb
    begin
        if (count_reg == 4'd0)
        begin
            ring_n = CW'(1);
        end
        else if (32'(count_reg) > NUM_TASKS)
        begin
            ring_n = CW'(NUM_TASKS);
        end
        else
        begin
            ring_n = CW'(count_reg);
        end
    end

    // First slot of the scan: the one after the current task, wrapping.
    logic [IW-1:0] base;
    logic [IW-1:0] first_idx;
    always_comb
    begin
        base = (32'(cur_reg) < 32'(ring_n)) ? cur_reg : IW'(ring_n - CW'(1));
        if (32'(base) + 1 >= 32'(ring_n))
        begin
            first_idx = '0;
        end
        else
        begin
            first_idx = base + IW'(1);
        end
    end

    logic tgt_ok;
    assign tgt_ok = (32'(in_word.task_index) < NUM_TASKS);

    logic eligible;
    assign eligible = (status_reg[idx_reg] != ST_BLOCKED)
                   && (status_reg[idx_reg] != ST_SLEEPING)
                   && (prio_reg[idx_reg] < best_reg);

    assign stat.scan_last = (left_reg == CW'(1));

    logic [IW-1:0] tgt;
    assign tgt = IW'(in_word.task_index);

    // Pre-scan update on load; scan steps; commit of the pick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                status_reg[i] <= ST_READY;
                prio_reg[i]   <= '0;
                sleep_reg[i]  <= '0;
                event_reg[i]  <= '0;
            end
            cur_reg   <= '0;
            count_reg <= TASK_COUNT_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                count_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                prev_reg   <= cur_reg;
                idx_reg    <= first_idx;
                left_reg   <= ring_n;
                best_reg   <= PRIO_NONE;
                found_reg  <= 1'b0;
                pick_reg   <= '0;
                tick_reg   <= 1'b0;
                sched_reg  <= 1'b0;
                woke_reg   <= 1'b0;
                case (in_word.action)
                    ACT_TICK:
                    begin
                        logic w;
                        w = 1'b0;
                        for (int i = 0; i < NUM_TASKS; i++)
                        begin
                            if (sleep_reg[i] != '0)
                            begin
                                sleep_reg[i] <= sleep_reg[i] - 32'd1;
                                if (sleep_reg[i] == 32'd1)
                                begin
                                    if (status_reg[i] == ST_SLEEPING)
                                    begin
                                        w = 1'b1;
                                    end
                                    status_reg[i] <= ST_READY;
                                end
                            end
                        end
                        woke_reg  <= w;
                        sched_reg <= 1'b1;
                        tick_reg  <= 1'b1;
                    end
                    ACT_YIELD:
                    begin
                        if (status_reg[cur_reg] == ST_RUNNING)
                        begin
                            status_reg[cur_reg] <= ST_READY;
                        end
                        sched_reg <= 1'b1;
                    end
                    ACT_SLEEP_TICKS:
                    begin
                        sleep_reg[cur_reg]  <= in_word.tick_count;
                        status_reg[cur_reg] <= ST_SLEEPING;
                        sched_reg           <= 1'b1;
                    end
                    ACT_SLEEP_EVENT:
                    begin
                        event_reg[cur_reg]  <= in_word.event_id;
                        status_reg[cur_reg] <= ST_SLEEPING;
                        sched_reg           <= 1'b1;
                    end
                    ACT_WAKE_TASK:
                    begin
                        if (tgt_ok)
                        begin
                            woke_reg        <= (status_reg[tgt] == ST_SLEEPING);
                            sleep_reg[tgt]  <= '0;
                            status_reg[tgt] <= ST_READY;
                        end
                    end
                    ACT_WAKE_EVENT:
                    begin
                        logic w;
                        w = 1'b0;
                        for (int i = 1; i < NUM_TASKS; i++)
                        begin
                            if (event_reg[i] == in_word.event_id
                                && status_reg[i] == ST_SLEEPING)
                            begin
                                event_reg[i]  <= '0;
                                status_reg[i] <= ST_READY;
                                w = 1'b1;
                            end
                        end
                        // A yield follows; the current task cannot be one woken here
                        // unless it was sleeping, so its running status is checked
                        // directly.
                        if (w && status_reg[cur_reg] == ST_RUNNING)
                        begin
                            status_reg[cur_reg] <= ST_READY;
                        end
                        woke_reg  <= w;
                        sched_reg <= w;
                    end
                    ACT_BLOCK:
                    begin
                        status_reg[cur_reg] <= ST_BLOCKED;
                        sched_reg           <= 1'b1;
                    end
                    ACT_UNBLOCK:
                    begin
                        if (tgt_ok && status_reg[tgt] == ST_BLOCKED)
                        begin
                            status_reg[tgt] <= ST_READY;
                        end
                    end
                    ACT_SET_PRIO:
                    begin
                        if (tgt_ok)
                        begin
                            prio_reg[tgt] <= in_word.new_priority;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.scan)
            begin
                if (eligible)
                begin
                    best_reg  <= prio_reg[idx_reg];
                    pick_reg  <= idx_reg;
                    found_reg <= 1'b1;
                end
                left_reg <= left_reg - CW'(1);
                if (32'(idx_reg) + 1 >= 32'(ring_n))
                begin
                    idx_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            if (cmd.commit)
            begin
                if (sched_reg && found_reg)
                begin
                    // On a tick the old current task is readied unless it is picked again.
                    if (tick_reg && (pick_reg != cur_reg))
                    begin
                        status_reg[cur_reg] <= ST_READY;
                    end
                    status_reg[pick_reg] <= ST_RUNNING;
                    cur_reg              <= pick_reg;
                end
                out_reg.switched      <= sched_reg && found_reg;
                out_reg.running_task  <= 3'((sched_reg && found_reg) ? pick_reg : cur_reg);
                out_reg.previous_task <= 3'(prev_reg);
                out_reg.woke_any      <= woke_reg;
            end
        end
    end

    assign out_word = out_reg;

endmodule

// ----- rtl/priority_task_scheduler.sv -----
// Channel | Direction | Handshake          | Word
// in      | input     | in_valid/in_stall  | in_word_t: action, task, ticks, event, priority
// out     | output    | out_valid/out_stall| out_word_t: switched, running, previous, woke
// cfg     | input     | cfg_valid/cfg_ready| task_count, 4 bits
// Each word goes through one load step, then a scan of every ring slot in turn
// through a single priority comparator, then one commit.
// Reset (rst_n low, asynchronous) readies all tasks, clears priorities, counts,
// events and the current task, and sets task_count to 8.
// A stalled result holds in the output register; no new word is taken until
// the previous one has been committed.
module priority_task_scheduler
    import pts_pkg::*;
#(
    parameter int NUM_TASKS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [3:0] cfg_data
);

    pts_cmd_t  cmd;
    pts_stat_t stat;

    assign cfg_ready = 1'b1;

    pts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    pts_datapath #(.NUM_TASKS(NUM_TASKS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_word  (out_word)
    );

`ifndef SYNTHESIS
    // A word is taken only when no result is being built.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !cmd.load)
        else $error("load repeated");
    // Commit only when the output register can take the result.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("commit lost");
    // A word is loaded only while the input is not stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && in_valid) |-> !in_stall)
        else $error("load while stalled");
`endif

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import pts_pkg::*;

    localparam int SLOTS = 8;
    localparam int STALL_LIMIT = 20000;

    // Predicts scheduler results and checks the words that come back.
    class sched_scoreboard;
        logic [1:0]  status [SLOTS];
        logic [7:0]  prio [SLOTS];
        logic [31:0] sleep_left [SLOTS];
        logic [31:0] wait_ev [SLOTS];
        int unsigned cur;
        int unsigned ring_cfg;
        out_word_t   pending [$];
        int          mismatches;

        function void clear_state();
            for (int i = 0; i < SLOTS; i++)
            begin
                status[i] = ST_READY;
                prio[i] = 8'd0;
                sleep_left[i] = 32'd0;
                wait_ev[i] = 32'd0;
            end
            cur = 0;
            ring_cfg = TASK_COUNT_RESET;
            mismatches = 0;
        endfunction

        function int unsigned ring_len();
            int unsigned n;
            n = ring_cfg;
            if (n == 0) n = 1;
            if (n > SLOTS) n = SLOTS;
            return n;
        endfunction

        // Scan the ring after the current task; strict less-than rotates ties.
        function bit choose(output int unsigned pick);
            int unsigned n;
            int unsigned base;
            int unsigned idx;
            int unsigned best;
            bit found;
            n = ring_len();
            base = (cur < n) ? cur : n - 1;
            best = PRIO_NONE;
            found = 0;
            pick = 0;
            for (int unsigned k = 1; k <= n; k++)
            begin
                idx = (base + k) % n;
                if (status[idx] != ST_BLOCKED && status[idx] != ST_SLEEPING &&
                    prio[idx] < best)
                begin
                    best = prio[idx];
                    pick = idx;
                    found = 1;
                end
            end
            return found;
        endfunction

        function bit reschedule();
            int unsigned pick;
            if (status[cur] == ST_RUNNING) status[cur] = ST_READY;
            if (!choose(pick)) return 0;
            cur = pick;
            status[pick] = ST_RUNNING;
            return 1;
        endfunction

        // Note an accepted input word: update the model and queue the result.
        function void note_word(in_word_t w);
            out_word_t r;
            int unsigned pick;
            bit sw;
            bit woke;
            sw = 0;
            woke = 0;
            r.previous_task = cur[2:0];
            case (w.action)
                ACT_TICK:
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (sleep_left[i] != 0)
                        begin
                            sleep_left[i]--;
                            if (sleep_left[i] == 0)
                            begin
                                if (status[i] == ST_SLEEPING) woke = 1;
                                status[i] = ST_READY;
                            end
                        end
                    if (choose(pick))
                    begin
                        status[cur] = ST_READY;
                        cur = pick;
                        status[pick] = ST_RUNNING;
                        sw = 1;
                    end
                end
                ACT_YIELD: sw = reschedule();
                ACT_SLEEP_TICKS:
                begin
                    sleep_left[cur] = w.tick_count;
                    status[cur] = ST_SLEEPING;
                    sw = reschedule();
                end
                ACT_SLEEP_EVENT:
                begin
                    wait_ev[cur] = w.event_id;
                    status[cur] = ST_SLEEPING;
                    sw = reschedule();
                end
                ACT_WAKE_TASK:
                begin
                    if (status[w.task_index] == ST_SLEEPING) woke = 1;
                    sleep_left[w.task_index] = 32'd0;
                    status[w.task_index] = ST_READY;
                end
                ACT_WAKE_EVENT:
                begin
                    for (int i = 1; i < SLOTS; i++)
                        if (wait_ev[i] == w.event_id && status[i] == ST_SLEEPING)
                        begin
                            wait_ev[i] = 32'd0;
                            status[i] = ST_READY;
                            woke = 1;
                        end
                    if (woke) sw = reschedule();
                end
                ACT_BLOCK:
                begin
                    status[cur] = ST_BLOCKED;
                    sw = reschedule();
                end
                ACT_UNBLOCK:
                    if (status[w.task_index] == ST_BLOCKED)
                        status[w.task_index] = ST_READY;
                ACT_SET_PRIO: prio[w.task_index] = w.new_priority;
                default: ;
            endcase
            r.switched = sw;
            r.running_task = cur[2:0];
            r.woke_any = woke;
            pending.push_back(r);
        endfunction

        function void fail(string msg);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", msg);
        endfunction

        // Compare one output word with the oldest expectation.
        function void check_word(out_word_t got);
            out_word_t exp_w;
            if (pending.size() == 0)
            begin
                fail($sformatf("unexpected word %p", got));
                return;
            end
            exp_w = pending.pop_front();
            if (got.switched !== exp_w.switched)
                fail($sformatf("switched exp %0d got %0d", exp_w.switched, got.switched));
            if (got.running_task !== exp_w.running_task)
                fail($sformatf("running exp %0d got %0d",
                    exp_w.running_task, got.running_task));
            if (got.previous_task !== exp_w.previous_task)
                fail($sformatf("previous exp %0d got %0d",
                    exp_w.previous_task, got.previous_task));
            if (got.woke_any !== exp_w.woke_any)
                fail($sformatf("woke exp %0d got %0d", exp_w.woke_any, got.woke_any));
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_word;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [3:0] cfg_data;

    sched_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    bit timed_out;

    priority_task_scheduler DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word (out_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: random stall, check at the rising edge.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check_word(out_word);
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog on cycles with no traffic.
    always @(posedge clk)
        if (quiet_cycles >= STALL_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("simulation failed");
            $finish;
        end

    // Valid stays high after acceptance until the next word or an idle cycle.
    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_word <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_word(w);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_ring(logic [3:0] n);
        drain();
        cfg_data <= n;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.ring_cfg = n;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_word_t make_word(logic [3:0] act, logic [2:0] idx,
                                           logic [31:0] ticks, logic [31:0] ev,
                                           logic [7:0] p);
        in_word_t w;
        w.action = act;
        w.task_index = idx;
        w.tick_count = ticks;
        w.event_id = ev;
        w.new_priority = p;
        return w;
    endfunction

    // Mostly well-formed scheduler traffic: small tick counts, few events.
    function automatic in_word_t random_word();
        in_word_t w;
        int sel;
        w = in_word_t'($bits(in_word_t)'({$urandom, $urandom, $urandom}));
        sel = $urandom_range(99);
        if (sel < 15) w.action = ACT_TICK;
        else if (sel < 25) w.action = ACT_YIELD;
        else if (sel < 35) w.action = ACT_SLEEP_TICKS;
        else if (sel < 45) w.action = ACT_SLEEP_EVENT;
        else if (sel < 55) w.action = ACT_WAKE_TASK;
        else if (sel < 67) w.action = ACT_WAKE_EVENT;
        else if (sel < 74) w.action = ACT_BLOCK;
        else if (sel < 84) w.action = ACT_UNBLOCK;
        else if (sel < 96) w.action = ACT_SET_PRIO;
        else w.action = 4'($urandom_range(9, 15));
        if ($urandom_range(9) != 0) w.tick_count = $urandom_range(6);
        if ($urandom_range(9) != 0) w.event_id = $urandom_range(3);
        if ($urandom_range(3) != 0) w.new_priority = 8'($urandom_range(4));
        else if ($urandom_range(3) == 0) w.new_priority = PRIO_NONE;
        return w;
    endfunction

    initial
    begin
        logic [3:0] rings [6];
        sb = new();
        sb.clear_state();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_valid = 1'b0;
        cfg_data = 4'd0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rings = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every action, field extremes and the corner cases.
        send_word(make_word(ACT_TICK, 3'd0, 32'd0, 32'd0, 8'd0));
        send_word(make_word(ACT_SET_PRIO, 3'd7, 32'd0, 32'd0, 8'd255));
        send_word(make_word(ACT_SET_PRIO, 3'd2, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd1));
        send_word(make_word(ACT_YIELD, 3'd0, 32'd0, 32'd0, 8'd0));
        send_word(make_word(ACT_SLEEP_TICKS, 3'd0, 32'd2, 32'd0, 8'd0));
        send_word(make_word(ACT_SLEEP_TICKS, 3'd0, 32'hFFFFFFFF, 32'd0, 8'd0));
        send_word(make_word(ACT_TICK, 3'd0, 32'd0, 32'd0, 8'd0));
        send_word(make_word(ACT_TICK, 3'd0, 32'd0, 32'd0, 8'd0));
        send_word(make_word(ACT_SLEEP_EVENT, 3'd0, 32'd0, 32'h80000000, 8'd0));
        send_word(make_word(ACT_SLEEP_EVENT, 3'd0, 32'd0, 32'h7FFFFFFF, 8'd0));
        send_word(make_word(ACT_WAKE_EVENT, 3'd0, 32'd0, 32'h80000000, 8'd0));
        send_word(make_word(ACT_WAKE_EVENT, 3'd0, 32'd0, 32'd12345, 8'd0));
        send_word(make_word(ACT_WAKE_TASK, 3'd1, 32'd0, 32'd0, 8'd0));
        send_word(make_word(ACT_WAKE_TASK, 3'd5, 32'd0, 32'd0, 8'd0));
        send_word(make_word(ACT_BLOCK, 3'd0, 32'd0, 32'd0, 8'd0));
        send_word(make_word(ACT_UNBLOCK, 3'd0, 32'd0, 32'd0, 8'd0));
        send_word(make_word(ACT_UNBLOCK, 3'd4, 32'd0, 32'd0, 8'd0));
        send_word(make_word(4'd9, 3'd7, 32'd0, 32'd0, 8'd0));
        send_word(make_word(4'd15, 3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255));
        send_word(make_word(ACT_SLEEP_TICKS, 3'd0, 32'd0, 32'd0, 8'd0));
        send_word(make_word(ACT_TICK, 3'd0, 32'd0, 32'd0, 8'd0));
        for (int i = 0; i < SLOTS; i++)
            send_word(make_word(ACT_BLOCK, 3'd0, 32'd0, 32'd0, 8'd0));
        send_word(make_word(ACT_YIELD, 3'd0, 32'd0, 32'd0, 8'd0));

        // Random phases across ring sizes and idling modes.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_ring(rings[ph]);
            send_idle_pct = (ph < 2) ? 13 : (ph < 4) ? 47 : 0;
            recv_idle_pct = (ph < 2) ? 47 : (ph < 4) ? 13 : 0;
            for (int n = 0; n < 220; n++)
            begin
                send_word(random_word());
                if (n == 100) drain();
            end
        end

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
